/* design/lsag_pkg.sv */
// Shared types, codes and the color wheel function of the LED strip animation generator.
package lsag_pkg;

  // Input item kinds carried on the input tuser bit.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_STEP_TIME = 3'd0;
  localparam logic [15:0] STEP_TIME_RESET = 16'd20;

  // Multiplier that spreads the wipe color over the wheel.
  localparam logic [7:0] WIPE_HUE_STEP = 8'd76;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_WHEEL  = 2'd1,
    MODE_SIMPLE = 2'd2,
    MODE_WIPE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    JOB_BLACK  = 2'd0,
    JOB_WHEEL  = 2'd1,
    JOB_SIMPLE = 2'd2,
    JOB_WIPE   = 2'd3
  } job_kind_t;

  // One unit of output work handed from the front to the back.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] color_pos;
    logic [5:0] wipe_idx;
  } job_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  // Standard wheel: position 0..255 to {red, green, blue}.
  function automatic logic [23:0] wheel_colour(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] wr;
    logic [9:0] t;
    logic [7:0] w3;
    logic [23:0] rgb;
    w = ~pos;
    if (w < 8'd85) begin
      wr = w;
    end else if (w < 8'd170) begin
      wr = w - 8'd85;
    end else begin
      wr = w - 8'd170;
    end
    t = {2'b00, wr} * 10'd3;
    w3 = t[7:0];
    if (w < 8'd85) begin
      rgb = {~w3, 8'd0, w3};
    end else if (w < 8'd170) begin
      rgb = {8'd0, w3, ~w3};
    end else begin
      rgb = {w3, ~w3, 8'd0};
    end
    return rgb;
  endfunction

endpackage

/* design/lsag_front.sv */
// Front end: accepts ticks and mode selections, keeps the animation state, issues jobs.
module lsag_front #(
  parameter int LED_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [1:0]        mode,
  input  logic [15:0]       step_time,
  output logic              push,
  output lsag_pkg::job_t    push_job,
  input  logic              push_ready
);

  localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);
  localparam logic [7:0] WIPE_HUE_STEP_W = lsag_pkg::WIPE_HUE_STEP;

  lsag_pkg::mode_t active_mode_r, active_mode_nxt;
  logic [7:0]  wheel_pos_r, wheel_pos_nxt;
  logic [7:0]  wipe_div_r, wipe_div_nxt;
  logic [5:0]  wipe_mod_r, wipe_mod_nxt;
  logic [17:0] ticks_r, ticks_nxt;

  logic        accept;
  logic [17:0] step18;
  logic [17:0] period;
  logic [15:0] hue_prod;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign step18   = {2'b00, step_time};
  assign hue_prod = wipe_div_r * WIPE_HUE_STEP_W;

  always_comb begin
    unique case (active_mode_r)
      lsag_pkg::MODE_SIMPLE: period = step18 << 2;
      lsag_pkg::MODE_WIPE:   period = step18 + (step18 << 1);
      default:               period = step18;
    endcase
  end

  always_comb begin
    active_mode_nxt = active_mode_r;
    wheel_pos_nxt   = wheel_pos_r;
    wipe_div_nxt    = wipe_div_r;
    wipe_mod_nxt    = wipe_mod_r;
    ticks_nxt       = ticks_r;
    push            = 1'b0;
    push_job.kind      = lsag_pkg::JOB_BLACK;
    push_job.color_pos = wheel_pos_r;
    push_job.wipe_idx  = wipe_mod_r;
    if (accept) begin
      if (cmd == lsag_pkg::CMD_SELECT) begin
        active_mode_nxt = lsag_pkg::mode_t'(mode);
        wheel_pos_nxt   = '0;
        wipe_div_nxt    = '0;
        wipe_mod_nxt    = '0;
        ticks_nxt       = '0;
        if (lsag_pkg::mode_t'(mode) == lsag_pkg::MODE_OFF) begin
          push = 1'b1;
        end
      end else if (active_mode_r != lsag_pkg::MODE_OFF) begin
        if (ticks_r != 18'd0) begin
          ticks_nxt = ticks_r - 18'd1;
        end else begin
          push = 1'b1;
          unique case (active_mode_r)
            lsag_pkg::MODE_WHEEL:  push_job.kind = lsag_pkg::JOB_WHEEL;
            lsag_pkg::MODE_SIMPLE: push_job.kind = lsag_pkg::JOB_SIMPLE;
            lsag_pkg::MODE_WIPE: begin
              push_job.kind      = lsag_pkg::JOB_WIPE;
              push_job.color_pos = hue_prod[7:0];
            end
            default:               push_job.kind = lsag_pkg::JOB_BLACK;
          endcase
          ticks_nxt = (step_time == 16'd0) ? 18'd0 : period - 18'd1;
          // Position, quotient and remainder by the strip length advance together.
          if (wheel_pos_r == 8'd255) begin
            wheel_pos_nxt = '0;
            wipe_div_nxt  = '0;
            wipe_mod_nxt  = '0;
          end else begin
            wheel_pos_nxt = wheel_pos_r + 8'd1;
            if (wipe_mod_r == LAST_IDX) begin
              wipe_mod_nxt = '0;
              wipe_div_nxt = wipe_div_r + 8'd1;
            end else begin
              wipe_mod_nxt = wipe_mod_r + 6'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_mode_r <= lsag_pkg::MODE_OFF;
      wheel_pos_r   <= '0;
      wipe_div_r    <= '0;
      wipe_mod_r    <= '0;
      ticks_r       <= '0;
    end else begin
      active_mode_r <= active_mode_nxt;
      wheel_pos_r   <= wheel_pos_nxt;
      wipe_div_r    <= wipe_div_nxt;
      wipe_mod_r    <= wipe_mod_nxt;
      ticks_r       <= ticks_nxt;
    end
  end

endmodule

/* design/lsag_queue.sv */
// Two-entry job queue between the front end and the pixel back end.
module lsag_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lsag_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output lsag_pkg::job_t pop_job
);

  lsag_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job = mem_r[rd_ptr_r];

endmodule

/* design/lsag_back.sv */
// Back end: expands jobs into registered pixel results, one per cycle unless stalled.
module lsag_back #(
  parameter int LED_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  lsag_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [5:0]     out_index,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_last
);

  localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);
  localparam logic [7:0] QSTEP    = 8'(256 / LED_COUNT);
  localparam logic [6:0] RSTEP    = 7'(256 % LED_COUNT);
  localparam logic [6:0] LEDS7    = 7'(LED_COUNT);

  lsag_pkg::back_state_t state_r, state_nxt;
  lsag_pkg::job_t job_r;
  logic [5:0] pix_r;
  logic [7:0] acc_q_r;
  logic [5:0] acc_rem_r;
  logic       out_valid_r;
  logic [5:0] out_index_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_last_r;

  logic       emit;
  logic       last_pix;
  logic [7:0] hue;
  logic [23:0] rgb;
  logic [6:0] rem_sum;

  assign last_pix = (job_r.kind == lsag_pkg::JOB_WIPE) || (pix_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsag_pkg::BK_IDLE: if (job_valid) state_nxt = lsag_pkg::BK_RUN;
      lsag_pkg::BK_RUN:  if (emit && last_pix) state_nxt = lsag_pkg::BK_IDLE;
      default:           state_nxt = lsag_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    emit    = 1'b0;
    unique case (state_r)
      lsag_pkg::BK_IDLE: job_pop = job_valid;
      lsag_pkg::BK_RUN:  emit = !out_valid_r || out_ready;
      default: begin
        job_pop = 1'b0;
        emit    = 1'b0;
      end
    endcase
  end

  always_comb begin
    hue = (job_r.kind == lsag_pkg::JOB_WHEEL) ? acc_q_r + job_r.color_pos : job_r.color_pos;
    rgb = (job_r.kind == lsag_pkg::JOB_BLACK) ? 24'd0 : lsag_pkg::wheel_colour(hue);
    rem_sum = {1'b0, acc_rem_r} + RSTEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsag_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pixel offset i*256/LED_COUNT is stepped as quotient plus remainder.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r     <= job;
      pix_r     <= '0;
      acc_q_r   <= '0;
      acc_rem_r <= '0;
    end else if (emit) begin
      pix_r <= pix_r + 6'd1;
      if (rem_sum >= LEDS7) begin
        acc_rem_r <= 6'(rem_sum - LEDS7);
        acc_q_r   <= acc_q_r + QSTEP + 8'd1;
      end else begin
        acc_rem_r <= rem_sum[5:0];
        acc_q_r   <= acc_q_r + QSTEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index_r <= (job_r.kind == lsag_pkg::JOB_WIPE) ? job_r.wipe_idx : pix_r;
      out_red_r   <= rgb[23:16];
      out_green_r <= rgb[15:8];
      out_blue_r  <= rgb[7:0];
      out_last_r  <= last_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_last  = out_last_r;

endmodule

/* design/led_strip_animation_generator_core.sv */
// An accepted item that causes results passes the job queue, the back end's job register
// and the output register before its first pixel shows. Throughput: a run of pixels
// leaves at one per cycle while the output is not stalled, with the back end idle between
// runs; an input item is taken whenever the two-entry job queue has room.
// Reset is synchronous and active low: mode off, wheel position and countdown zero,
// step time 20, job queue and output register empty.
module led_strip_animation_generator_core #(
  parameter int LED_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] mode, rest zero
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] pixel_index, [13:6] red, [21:14] green,
                                  // [29:22] blue, rest zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // The design splits into a front end that owns the animation state and decides, for
  // each accepted transaction, whether a run of pixels is due, and a back end that
  // expands each such job into pixel results. A short queue sits between them so a
  // stalled output never blocks tick bookkeeping until the queue fills.

  logic [15:0] step_time_r;
  logic        cfg_write;

  logic           q_push;
  logic           q_ready;
  logic           q_pop;
  logic           q_valid;
  lsag_pkg::job_t push_job;
  lsag_pkg::job_t pop_job;

  logic [5:0] pix_index;
  logic [7:0] pix_red, pix_green, pix_blue;

  // Configuration: a single register, step_time, at byte address zero.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == lsag_pkg::REG_STEP_TIME[2]);
  assign cfg_prdata = (cfg_paddr[2] == lsag_pkg::REG_STEP_TIME[2]) ?
                      {16'd0, step_time_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= lsag_pkg::STEP_TIME_RESET;
    end else if (cfg_write) begin
      step_time_r <= cfg_pwdata[15:0];
    end
  end

  lsag_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (in_tuser),
    .mode       (in_tdata[1:0]),
    .step_time  (step_time_r),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready)
  );

  lsag_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  lsag_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (pop_job),
    .job_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (pix_index),
    .out_red   (pix_red),
    .out_green (pix_green),
    .out_blue  (pix_blue),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, pix_blue, pix_green, pix_red, pix_index};

`ifndef SYNTHESIS
  // The back end only takes a job that the queue actually holds.
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  // The front end never issues a job the queue cannot store.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("job pushed into a full queue");

  // A full queue must have a job on offer to the back end.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_ready |-> q_valid)
    else $error("queue reports full and empty together");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
